// File: rtl/ddodo_pkg.sv
// Shared constants, state type and arctangent table for the odometry block.
`default_nettype none
package ddodo_pkg;

    localparam logic [30:0] RST_CIRC     = 31'd11534336;
    localparam logic [30:0] RST_BASE     = 31'd7864320;
    localparam logic [31:0] DEG_PER_TURN = 32'd360;
    // ceil(2^34 / 45): exact floor division by 45 for dividends below 2^28
    localparam logic [31:0] RECIP_45     = 32'd381774871;
    localparam logic [31:0] ANG_K        = 32'd683565276;
    localparam logic signed [32:0] CORDIC_GAIN_INV = 33'sd652032874;
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 5;
    localparam int DVD_W        = 69;
    localparam int CNT_W        = 7;
    localparam logic [CNT_W-1:0] DIV_STEPS_ANG   = 7'd69;

    localparam logic [2:0] CFG_CIRC          = 3'd0;
    localparam logic [2:0] CFG_BASE          = 3'd1;
    localparam logic [2:0] CFG_LEFT_INV      = 3'd2;
    localparam logic [2:0] CFG_RIGHT_INV     = 3'd3;
    localparam logic [2:0] CFG_START_X       = 3'd4;
    localparam logic [2:0] CFG_START_Y       = 3'd5;
    localparam logic [2:0] CFG_START_HEADING = 3'd6;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CQ,
        S_CR,
        S_L_MQ,
        S_L_MR,
        S_L_RC,
        S_L_ADD,
        S_R_MQ,
        S_R_MR,
        S_R_RC,
        S_R_ADD,
        S_DIFF,
        S_MUL_AL,
        S_MUL_AH,
        S_DIV_A,
        S_CORD_INIT,
        S_CORD,
        S_TRIG,
        S_MX_LO,
        S_MX_HI,
        S_MY_LO,
        S_MY_HI,
        S_UPDATE,
        S_OUT
    } t_state;

    function automatic logic [31:0] atan_bam(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10680862;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/ddodo_in_if.sv
// Input channel: encoder sample or restart item.
`default_nettype none
interface ddodo_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;

    modport source (output valid, output op, output left_count, output right_count,
                    input ready);
    modport sink   (input valid, input op, input left_count, input right_count,
                    output ready);
endinterface
`default_nettype wire

// File: rtl/ddodo_out_if.sv
// Output channel: pose result item.
`default_nettype none
interface ddodo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic        [31:0] pose_heading;
    logic               moved;

    modport source (output valid, output pose_x, output pose_y, output pose_heading,
                    output moved, input ready);
    modport sink   (input valid, input pose_x, input pose_y, input pose_heading,
                    input moved, output ready);
endinterface
`default_nettype wire

// File: rtl/differential_drive_odometry.sv
// Top level: differential-drive dead-reckoning pose tracker.
//
// One item at a time: a restart or a still sample gives its result in the cycle after
// it is accepted, and no new item is taken until that result is taken. A moving sample
// passes through the wheel-distance, heading-change division, CORDIC, position-step and
// update states before its result is shown. The work is done by a one-bit-a-cycle
// restoring divider for the heading change (69 steps), a 24-step CORDIC rotator and a
// shared 32x32 multiplier used in fourteen passes (wheel distances by reciprocal
// multiplication, the heading-change numerator and the two position steps).
// The input is ready only while idle and the result is held until taken. Configuration
// writes are taken every cycle and should be made while idle.
`default_nettype none
module differential_drive_odometry
    import ddodo_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    ddodo_in_if.sink    i_in,
    ddodo_out_if.source o_out,
    input  wire         i_cfg_wr_en,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [30:0] r_circ, r_base;
    logic        r_linv, r_rinv;
    logic [31:0] r_start_x, r_start_y, r_start_heading;
    logic [31:0] r_lbase, r_rbase, r_pos_x, r_pos_y, r_heading;
    logic        r_moved;

    logic [31:0] r_lc, r_rc;
    logic [15:0] r_lmag, r_rmag;
    logic        r_lneg, r_rneg;
    logic [22:0] r_cq;
    logic [8:0]  r_cr;
    logic [38:0] r_mq;
    logic [23:0] r_t;
    logic [15:0] r_q2;
    logic signed [39:0] r_dl, r_dr, r_avg;
    logic        r_dneg;
    logic [38:0] r_dmag;
    logic [DVD_W-1:0] r_acc, r_dvd;
    logic [31:0] r_rem;
    logic [30:0] r_div;
    logic [32:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0] r_full, r_ang;
    logic signed [32:0] r_cx, r_cy;
    logic signed [31:0] r_cz;
    logic [STEP_W-1:0] r_ci;
    logic [1:0]  r_quad;
    logic signed [26:0] r_c24, r_s24;
    logic [31:0] r_dx, r_dy;

    logic        w_in_acc;
    logic [31:0] w_lcu, w_rcu, w_lc, w_rc, w_ld, w_rd, w_lds, w_rds;
    logic [15:0] w_l16, w_r16;
    logic        w_still;
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_prod;
    logic [DVD_W-1:0] w_prod_ext, w_acc_hi;
    logic [31:0] w_trial, w_rem_n;
    logic        w_ge;
    logic [39:0] w_wd;
    logic signed [40:0] w_sum;
    logic signed [40:0] w_sum_adj;
    logic signed [39:0] w_d;
    logic [39:0] w_dabs;
    logic [30:0] w_base_div;
    logic [32:0] w_q33, w_f33, w_h33;
    logic [31:0] w_qa;
    logic signed [32:0] w_xs, w_ys, w_c, w_s, w_c_r, w_s_r;
    logic [31:0] w_atan;

    assign w_in_acc = i_in.valid & i_in.ready;

    assign w_lcu = i_in.left_count;
    assign w_rcu = i_in.right_count;
    assign w_lc  = w_lcu[31] ? (32'd0 - w_lcu) : w_lcu;
    assign w_rc  = w_rcu[31] ? (32'd0 - w_rcu) : w_rcu;
    assign w_ld  = w_lc - r_lbase;
    assign w_rd  = w_rc - r_rbase;
    assign w_lds = r_linv ? (32'd0 - w_ld) : w_ld;
    assign w_rds = r_rinv ? (32'd0 - w_rd) : w_rd;
    assign w_l16 = w_lds[15:0];
    assign w_r16 = w_rds[15:0];
    assign w_still = (w_l16 == 16'd0) && (w_r16 == 16'd0);

    assign w_prod     = w_ma * w_mb;
    assign w_prod_ext = {{(DVD_W-64){w_prod[63]}}, w_prod};
    assign w_acc_hi   = r_acc + {w_prod_ext[DVD_W-21:0], 20'd0};

    assign w_trial = {r_rem[30:0], r_dvd[DVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_rem_n = w_ge ? (w_trial - {1'b0, r_div}) : w_trial;

    // wheel distance magnitude: mag * (circ / 360) plus mag * (circ mod 360) / 360
    assign w_wd = {1'b0, r_mq + {23'd0, r_q2}};

    assign w_sum     = 41'(r_dl) + 41'(r_dr);
    assign w_sum_adj = w_sum + {40'd0, w_sum[40] & w_sum[0]};
    assign w_d       = r_dr - r_dl;
    assign w_dabs    = w_d[39] ? (40'd0 - w_d) : w_d;

    assign w_base_div = (r_base == 31'd0) ? 31'd1 : r_base;
    assign w_q33 = r_quo;
    assign w_f33 = r_dneg ? (33'd0 - w_q33) : w_q33;
    assign w_h33 = w_f33 + {32'd0, r_dneg & w_q33[0]};

    assign w_qa   = r_ang + 32'h2000_0000;
    assign w_xs   = r_cx >>> r_ci;
    assign w_ys   = r_cy >>> r_ci;
    assign w_atan = atan_bam(r_ci);

    always_comb begin
        case (r_quad)
            2'd0:    begin w_c = r_cx;  w_s = r_cy;  end
            2'd1:    begin w_c = -r_cy; w_s = r_cx;  end
            2'd2:    begin w_c = -r_cx; w_s = -r_cy; end
            default: begin w_c = r_cy;  w_s = -r_cx; end
        endcase
        w_c_r = (w_c + 33'sd32) >>> 6;
        w_s_r = (w_s + 33'sd32) >>> 6;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_in.op || w_still) ? S_OUT : S_CQ;
                end
            end
            S_CQ:        n_state = S_CR;
            S_CR:        n_state = S_L_MQ;
            S_L_MQ:      n_state = S_L_MR;
            S_L_MR:      n_state = S_L_RC;
            S_L_RC:      n_state = S_L_ADD;
            S_L_ADD:     n_state = S_R_MQ;
            S_R_MQ:      n_state = S_R_MR;
            S_R_MR:      n_state = S_R_RC;
            S_R_RC:      n_state = S_R_ADD;
            S_R_ADD:     n_state = S_DIFF;
            S_DIFF:      n_state = S_MUL_AL;
            S_MUL_AL:    n_state = S_MUL_AH;
            S_MUL_AH:    n_state = S_DIV_A;
            S_DIV_A:     n_state = (r_cnt == '0) ? S_CORD_INIT : S_DIV_A;
            S_CORD_INIT: n_state = S_CORD;
            S_CORD: begin
                if (r_ci == STEP_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_TRIG;
                end
            end
            S_TRIG:      n_state = S_MX_LO;
            S_MX_LO:     n_state = S_MX_HI;
            S_MX_HI:     n_state = S_MY_LO;
            S_MY_LO:     n_state = S_MY_HI;
            S_MY_HI:     n_state = S_UPDATE;
            S_UPDATE:    n_state = S_OUT;
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // multiplier operands
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_CQ: begin
                w_ma = {4'd0, r_circ[30:3]};
                w_mb = RECIP_45;
            end
            S_CR: begin
                w_ma = {9'd0, r_cq};
                w_mb = DEG_PER_TURN;
            end
            S_L_MQ: begin
                w_ma = {16'd0, r_lmag};
                w_mb = {9'd0, r_cq};
            end
            S_L_MR: begin
                w_ma = {16'd0, r_lmag};
                w_mb = {23'd0, r_cr};
            end
            S_R_MQ: begin
                w_ma = {16'd0, r_rmag};
                w_mb = {9'd0, r_cq};
            end
            S_R_MR: begin
                w_ma = {16'd0, r_rmag};
                w_mb = {23'd0, r_cr};
            end
            S_L_RC, S_R_RC: begin
                w_ma = {11'd0, r_t[23:3]};
                w_mb = RECIP_45;
            end
            S_MUL_AL: begin
                w_ma = {12'd0, r_dmag[19:0]};
                w_mb = ANG_K;
            end
            S_MUL_AH: begin
                w_ma = {13'd0, r_dmag[38:20]};
                w_mb = ANG_K;
            end
            S_MX_LO: begin
                w_ma = {12'd0, r_avg[19:0]};
                w_mb = {{5{r_s24[26]}}, r_s24};
            end
            S_MX_HI: begin
                w_ma = {{12{r_avg[39]}}, r_avg[39:20]};
                w_mb = {{5{r_s24[26]}}, r_s24};
            end
            S_MY_LO: begin
                w_ma = {12'd0, r_avg[19:0]};
                w_mb = {{5{r_c24[26]}}, r_c24};
            end
            S_MY_HI: begin
                w_ma = {{12{r_avg[39]}}, r_avg[39:20]};
                w_mb = {{5{r_c24[26]}}, r_c24};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = (r_state == S_OUT);
    assign o_out.pose_x       = r_pos_x;
    assign o_out.pose_y       = r_pos_y;
    assign o_out.pose_heading = r_heading;
    assign o_out.moved        = r_moved;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_circ          <= RST_CIRC;
            r_base          <= RST_BASE;
            r_linv          <= 1'b0;
            r_rinv          <= 1'b0;
            r_start_x       <= '0;
            r_start_y       <= '0;
            r_start_heading <= '0;
            r_lbase         <= '0;
            r_rbase         <= '0;
            r_pos_x         <= '0;
            r_pos_y         <= '0;
            r_heading       <= '0;
            r_moved         <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_CIRC:          r_circ          <= i_cfg_data[30:0];
                    CFG_BASE:          r_base          <= i_cfg_data[30:0];
                    CFG_LEFT_INV:      r_linv          <= i_cfg_data[0];
                    CFG_RIGHT_INV:     r_rinv          <= i_cfg_data[0];
                    CFG_START_X:       r_start_x       <= i_cfg_data;
                    CFG_START_Y:       r_start_y       <= i_cfg_data;
                    CFG_START_HEADING: r_start_heading <= i_cfg_data;
                    default:           ;
                endcase
            end
            if (w_in_acc) begin
                r_moved <= 1'b0;
                if (i_in.op) begin
                    r_pos_x   <= r_start_x;
                    r_pos_y   <= r_start_y;
                    r_heading <= r_start_heading;
                    r_lbase   <= w_lc;
                    r_rbase   <= w_rc;
                end
            end
            if (r_state == S_UPDATE) begin
                r_pos_x   <= r_pos_x - r_dx;
                r_pos_y   <= r_pos_y + r_dy;
                r_heading <= r_heading + r_full;
                r_lbase   <= r_lc;
                r_rbase   <= r_rc;
                r_moved   <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_lc   <= w_lc;
                r_rc   <= w_rc;
                r_lneg <= w_l16[15];
                r_rneg <= w_r16[15];
                r_lmag <= w_l16[15] ? (16'd0 - w_l16) : w_l16;
                r_rmag <= w_r16[15] ? (16'd0 - w_r16) : w_r16;
            end
            S_CQ:             r_cq <= w_prod[56:34];
            S_CR:             r_cr <= r_circ[8:0] - w_prod[8:0];
            S_L_MQ, S_R_MQ:   r_mq <= w_prod[38:0];
            S_L_MR, S_R_MR:   r_t  <= w_prod[23:0];
            S_L_RC, S_R_RC:   r_q2 <= w_prod[49:34];
            S_L_ADD:          r_dl <= r_lneg ? (40'd0 - w_wd) : w_wd;
            S_R_ADD:          r_dr <= r_rneg ? (40'd0 - w_wd) : w_wd;
            S_DIV_A: begin
                if (r_cnt != '0) begin
                    r_rem <= w_rem_n;
                    r_quo <= {r_quo[31:0], w_ge};
                    r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                end else begin
                    r_full <= w_f33[31:0];
                    r_ang  <= r_heading + w_h33[32:1];
                end
            end
            S_DIFF: begin
                r_avg  <= w_sum_adj[40:1];
                r_dneg <= w_d[39];
                r_dmag <= w_dabs[38:0];
            end
            S_MUL_AL: r_acc <= w_prod_ext;
            S_MUL_AH: begin
                r_dvd <= w_acc_hi;
                r_rem <= '0;
                r_div <= w_base_div;
                r_cnt <= DIV_STEPS_ANG;
            end
            S_CORD_INIT: begin
                r_quad <= w_qa[31:30];
                r_cz   <= r_ang - {w_qa[31:30], 30'd0};
                r_cx   <= CORDIC_GAIN_INV;
                r_cy   <= '0;
                r_ci   <= '0;
            end
            S_CORD: begin
                if (!r_cz[31]) begin
                    r_cx <= r_cx - w_ys;
                    r_cy <= r_cy + w_xs;
                    r_cz <= r_cz - w_atan;
                end else begin
                    r_cx <= r_cx + w_ys;
                    r_cy <= r_cy - w_xs;
                    r_cz <= r_cz + w_atan;
                end
                r_ci <= r_ci + 1'b1;
            end
            S_TRIG: begin
                r_c24 <= w_c_r[26:0];
                r_s24 <= w_s_r[26:0];
            end
            S_MX_LO, S_MY_LO: r_acc <= w_prod_ext + DVD_W'(24'h80_0000);
            S_MX_HI: r_dx <= w_acc_hi[55:24];
            S_MY_HI: r_dy <= w_acc_hi[55:24];
            default: ;
        endcase
    end

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while a result is pending");

    a_restart_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in.op) |=> (r_pos_x == $past(r_start_x)) && !r_moved)
        else $error("restart did not load the start pose");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_A) |-> (r_rem < {1'b0, r_div}))
        else $error("divider remainder out of range");

    a_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_in.op && w_still) |=> o_out.valid && !r_moved)
        else $error("still sample not answered at once");

endmodule
`default_nettype wire
